@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Each macro expects clk in the scope where it is used; CWM_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define CWM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CWM_ASSERT_NR(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CWM_ASSERT(name, prop, msg)
`define CWM_ASSERT_NR(name, prop, msg)

`endif

`endif

@@ rtl/core/cwm_pkg.sv @@
package cwm_pkg;

	// Field widths
	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int BLANK_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 2;

	// Averaging window
	localparam int AVG_DEPTH = 8;
	localparam int DEPTH_LOG = $clog2(AVG_DEPTH);
	localparam int HEAD_W    = (AVG_DEPTH > 1) ? DEPTH_LOG : 1;
	localparam int SUM_W     = SAMPLE_W + DEPTH_LOG;

	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(AVG_DEPTH - 1);
	localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(((2 ** SAMPLE_W) - 1) * AVG_DEPTH);

	// Divide by AVG_DEPTH as multiply by a rounded-up reciprocal; exact for any SUM_W-bit sum
	localparam int DIV_SHIFT = SUM_W + DEPTH_LOG;
	localparam int MULT_W    = DIV_SHIFT + 1;
	localparam int PROD_W    = SUM_W + MULT_W;
	localparam logic [MULT_W-1:0] DIV_MULT =
		MULT_W'(((2 ** DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_STOP   = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW   = 2'd0,
		CFG_HIGH  = 2'd1,
		CFG_BLANK = 2'd2
	} cfg_idx_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic samp;        // sample tick taken while monitoring
		logic start;       // start that turns monitoring on
		logic blank_done;  // item time lies past the blanking window
		logic mon;         // monitoring after this item
	} item_ctl_t;

	typedef struct packed {
		logic              en;
		logic [HEAD_W-1:0] addr;
	} ring_rd_t;

	typedef struct packed {
		logic                en;
		logic [HEAD_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} ring_wr_t;

endpackage

@@ rtl/core/cwm_ring.sv @@
`include "assert_macros.svh"

module cwm_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwm_pkg::ring_rd_t             rd,
	input  cwm_pkg::ring_wr_t             wr,
	output logic [cwm_pkg::SAMPLE_W-1:0]  old_sample
);
	import cwm_pkg::*;

	logic [SAMPLE_W-1:0]  mem [AVG_DEPTH];
	logic [SAMPLE_W-1:0]  rd_data_q;
	logic [AVG_DEPTH-1:0] valid_q;
	logic                 rd_valid_q;
	logic                 fwd_hit_q;
	logic [SAMPLE_W-1:0]  fwd_data_q;

	// Sample storage: registered read, single write port
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Forward data written on the same edge as a read of that entry
	always_ff @(posedge clk) begin
		if (rd.en) begin
			fwd_data_q <= wr.data;
		end
	end

	// Track written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_valid_q <= valid_q[rd.addr];
				fwd_hit_q  <= wr.en && (wr.addr == rd.addr);
			end
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			old_sample = fwd_data_q;
		end else if (rd_valid_q) begin
			old_sample = rd_data_q;
		end else begin
			old_sample = '0;
		end
	end

	`CWM_ASSERT(a_ring_fwd, rd.en && wr.en && (rd.addr == wr.addr) |=> old_sample == $past(wr.data), "ring read missed data written on the same edge")

endmodule

@@ rtl/core/current_window_monitor_top.sv @@
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_ready    | func, sample, now_ms
// out      | out_valid / out_ready  | status, average, changed, event_sample, monitoring
// cfg      | cfg_we (write only)    | cfg_index, cfg_wdata
//
// One item per cycle while out_ready allows; an item passes stage 1 (ring read and sum
// update), stage 2 (reciprocal multiply) and stage 3 (classify into the output
// register) on its way to out_valid.
// The sum and the ring are updated once per sample in stage 1; a write and a
// read of the same entry on one edge are resolved by forwarding.
// Reset clears the ring through per-entry valid bits, so items are taken right away.
// A stalled output stage holds; earlier stages keep filling until all are occupied.
`include "assert_macros.svh"

module current_window_monitor_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cwm_pkg::FUNC_W-1:0]      func,
	input  logic [cwm_pkg::SAMPLE_W-1:0]    sample,
	input  logic [cwm_pkg::TIME_W-1:0]      now_ms,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cwm_pkg::STATUS_W-1:0]    status,
	output logic [cwm_pkg::SAMPLE_W-1:0]    average,
	output logic                            changed,
	output logic [cwm_pkg::SAMPLE_W-1:0]    event_sample,
	output logic                            monitoring
);
	import cwm_pkg::*;

	// Configuration registers
	logic [SAMPLE_W-1:0] low_q;
	logic [SAMPLE_W-1:0] high_q;
	logic [BLANK_W-1:0]  blank_q;

	// Front-end state, updated at input transfer
	logic                enabled_q;
	logic [TIME_W-1:0]   start_time_q;
	logic [HEAD_W-1:0]   head_q;

	// Pipeline
	logic                v_s1, v_s2, v_s3, out_v_q;
	item_ctl_t           ctl_s1, ctl_s2, ctl_s3;
	logic [SAMPLE_W-1:0] sample_s1, sample_s2, sample_s3;
	logic [HEAD_W-1:0]   head_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] avg_s3;

	// Result state
	status_t             status_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic                changed_q;
	logic [SAMPLE_W-1:0] event_q;
	logic                mon_q;

	logic ready_out, ready_s3, ready_s2, ready_s1;
	logic in_fire, s1_mv, s2_mv, s3_mv;

	item_ctl_t           ctl_in;
	logic                blank_done;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    sum_next;
	logic [PROD_W-1:0]   prod;
	status_t             class_st;
	status_t             status_next;
	logic                chg_next;

	ring_rd_t ring_rd;
	ring_wr_t ring_wr;

	// Stage handshakes: a stage takes new data when empty or when it moves on
	assign ready_out = !out_v_q || out_ready;
	assign ready_s3  = !v_s3 || ready_out;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_ready  = ready_s1;

	assign in_fire = in_valid && in_ready;
	assign s1_mv   = v_s1 && ready_s2;
	assign s2_mv   = v_s2 && ready_s3;
	assign s3_mv   = v_s3 && ready_out;

	// Decode the item against the state before it
	assign blank_done = {1'b0, now_ms} >
		({1'b0, start_time_q} + (TIME_W + 1)'(blank_q));

	always_comb begin
		ctl_in.samp       = (func == FUNC_SAMPLE) && enabled_q;
		ctl_in.start      = (func == FUNC_START) && !enabled_q;
		ctl_in.blank_done = blank_done;
		if (func == FUNC_START) begin
			ctl_in.mon = 1'b1;
		end else if (func == FUNC_STOP) begin
			ctl_in.mon = 1'b0;
		end else begin
			ctl_in.mon = enabled_q;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '1;
			blank_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW:   low_q   <= cfg_wdata[SAMPLE_W-1:0];
				CFG_HIGH:  high_q  <= cfg_wdata[SAMPLE_W-1:0];
				CFG_BLANK: blank_q <= cfg_wdata[BLANK_W-1:0];
				default:   ;
			endcase
		end
	end

	// Front end: enable, start time and ring head advance at transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			start_time_q <= '0;
			head_q       <= '0;
		end else if (in_fire) begin
			enabled_q <= ctl_in.mon;
			if (ctl_in.start) begin
				start_time_q <= now_ms;
			end
			if (ctl_in.samp) begin
				head_q <= (head_q == HEAD_LAST) ? '0 : head_q + HEAD_W'(1);
			end
		end
	end

	// Ring accesses: read at transfer, write as the item leaves stage 1
	assign ring_rd.en   = in_fire;
	assign ring_rd.addr = head_q;
	assign ring_wr.en   = s1_mv && ctl_s1.samp;
	assign ring_wr.addr = head_s1;
	assign ring_wr.data = sample_s1;

	cwm_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd         (ring_rd),
		.wr         (ring_wr),
		.old_sample (old_sample)
	);

	// Replace the oldest sample in the running sum
	assign sum_next = sum_q - SUM_W'(old_sample) + SUM_W'(sample_s1);

	// Average by reciprocal multiply
	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV_MULT);

	// Classify against the thresholds; overcurrent wins when they cross
	always_comb begin
		class_st = ST_OK;
		if (ctl_s3.blank_done) begin
			if (avg_s3 > high_q) begin
				class_st = ST_OVER;
			end else if (avg_s3 < low_q) begin
				class_st = ST_UNDER;
			end
		end
		status_next = status_q;
		chg_next    = 1'b0;
		if (ctl_s3.samp) begin
			status_next = class_st;
			chg_next    = (class_st != status_q);
		end else if (ctl_s3.start) begin
			status_next = ST_OK;
		end
	end

	// Pipeline valid bits, running sum and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			out_v_q  <= 1'b0;
			sum_q    <= '0;
			status_q <= ST_OK;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_out) begin
				out_v_q <= v_s3;
			end
			if (s1_mv && ctl_s1.samp) begin
				sum_q <= sum_next;
			end
			if (s3_mv) begin
				status_q <= status_next;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1    <= ctl_in;
			sample_s1 <= sample;
			head_s1   <= head_q;
		end
		if (s1_mv) begin
			ctl_s2    <= ctl_s1;
			sample_s2 <= sample_s1;
			sum_s2    <= ctl_s1.samp ? sum_next : sum_q;
		end
		if (s2_mv) begin
			ctl_s3    <= ctl_s2;
			sample_s3 <= sample_s2;
			avg_s3    <= prod[DIV_SHIFT +: SAMPLE_W];
		end
		if (s3_mv) begin
			avg_q     <= avg_s3;
			changed_q <= chg_next;
			event_q   <= chg_next ? sample_s3 : '0;
			mon_q     <= ctl_s3.mon;
		end
	end

	assign out_valid    = out_v_q;
	assign status       = status_q;
	assign average      = avg_q;
	assign changed      = changed_q;
	assign event_sample = event_q;
	assign monitoring   = mon_q;

	`CWM_ASSERT(a_chg_mon, out_valid && changed |-> monitoring, "status change reported while not monitoring")
	`CWM_ASSERT(a_evt_zero, out_valid && !changed |-> event_sample == '0, "event sample set without a status change")
	`CWM_ASSERT(a_start_ok, s3_mv && ctl_s3.start |=> status_q == ST_OK, "start did not clear the status")
	`CWM_ASSERT(a_sum_bound, sum_q <= SUM_MAX, "running sum exceeds window maximum")

endmodule
